/* rtl/bffsa_pkg.sv */
// Shared types and constants for the bitmap first-fit sector allocator.
package bffsa_pkg;

    localparam int MAP_BYTES    = 128;
    localparam int SECTOR_BYTES = 64;   // power of two
    localparam int MAP_AW       = $clog2(MAP_BYTES);
    localparam int TOTAL        = MAP_BYTES * 8;
    localparam int SEC_W        = 10;   // start_sector field width
    localparam int NEED_W       = $clog2(TOTAL) + 2;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_LOADED  = 2'd2
    } t_status;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_LOAD  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR
    } t_state;

    typedef struct packed {
        logic        func;
        logic [15:0] size_bytes;
        logic [6:0]  map_index;
        logic [7:0]  map_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  start_sector;
        logic [15:0] start_address;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [MAP_AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              hit;
        logic [2:0]        pos;
        logic [NEED_W-1:0] run;
    } t_scan_res;

endpackage

/* rtl/bffsa_map_ram.sv */
// Sector map memory with per-byte valid bits; unwritten bytes read as zero.
module bffsa_map_ram (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bffsa_pkg::t_ram_req      i_req,
    output logic [7:0]               o_rdata
);

    logic [7:0]                mem [bffsa_pkg::MAP_BYTES];
    logic [bffsa_pkg::MAP_BYTES-1:0] r_vld;
    logic [7:0]                r_rdata;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : 8'h00;

endmodule

/* rtl/bffsa_byte_scan.sv */
// Walks the eight sector bits of one map byte, extending the free run.
module bffsa_byte_scan (
    input  logic [7:0]                    i_byte,
    input  logic [bffsa_pkg::NEED_W-1:0]  i_run,
    input  logic [bffsa_pkg::NEED_W-1:0]  i_need,
    output bffsa_pkg::t_scan_res          o_res
);

    always_comb begin
        logic [bffsa_pkg::NEED_W-1:0] run;
        logic                         hit;
        logic [2:0]                   pos;
        run = i_run;
        hit = 1'b0;
        pos = 3'd0;
        for (int j = 0; j < 8; j++) begin
            if (!hit) begin
                if (i_byte[j]) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                    if (run == i_need) begin
                        hit = 1'b1;
                        pos = 3'(j);
                    end
                end
            end
        end
        o_res.hit = hit;
        o_res.pos = pos;
        o_res.run = run;
    end

endmodule

/* rtl/bitmap_first_fit_sector_allocator.sv */
// Top level: first-fit sector allocator over a byte-wide sector map memory.
// Load or zero-size item: result strobed in the cycle after acceptance, busy stays low.
// Allocate item: a scan of one map byte per cycle, with the read running one byte ahead of
// the check, then a read and a write of each map byte touched by the run before the result.
// One item at a time: busy drops in the result cycle; the receiver cannot stall results.
// Synchronous active-low reset clears control and the map valid bits at once.
module bitmap_first_fit_sector_allocator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bffsa_pkg::t_in_item   i_item,
    output logic                  o_strobe,
    output bffsa_pkg::t_out_item  o_result
);

    // FSM and scan/mark bookkeeping
    bffsa_pkg::t_state                r_state, n_state;
    logic [bffsa_pkg::MAP_AW:0]       r_rd_idx, n_rd_idx;     // next byte to read
    logic                             r_chk_vld, n_chk_vld;   // read data in flight
    logic [bffsa_pkg::MAP_AW-1:0]     r_chk_idx, n_chk_idx;   // byte of that data
    logic [bffsa_pkg::NEED_W-1:0]     r_run, n_run;
    logic [bffsa_pkg::NEED_W-1:0]     r_need, n_need;
    logic [bffsa_pkg::SEC_W-1:0]      r_start, n_start;
    logic [bffsa_pkg::SEC_W-1:0]      r_end, n_end;
    logic [bffsa_pkg::MAP_AW-1:0]     r_mark_idx, n_mark_idx;
    logic                             r_strobe, n_strobe;
    bffsa_pkg::t_out_item             r_result, n_result;

    bffsa_pkg::t_ram_req              ram_req;
    logic [7:0]                       ram_rdata;
    bffsa_pkg::t_scan_res             scan;

    logic [bffsa_pkg::NEED_W-1:0]     need;
    logic [bffsa_pkg::SEC_W-1:0]      hit_end;
    logic [bffsa_pkg::SEC_W-1:0]      hit_start;
    logic [2:0]                       mask_lo, mask_hi;
    logic [7:0]                       mark_mask;

    bffsa_map_ram u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    bffsa_byte_scan u_scan (
        .i_byte (ram_rdata),
        .i_run  (r_run),
        .i_need (r_need),
        .o_res  (scan)
    );

    // ceil(size / sector) by shift, since sector size is a power of two
    assign need = bffsa_pkg::NEED_W'(
        ({1'b0, i_item.size_bytes} + 17'(bffsa_pkg::SECTOR_BYTES - 1))
        >> bffsa_pkg::SECTOR_SHIFT);

    // run ends at the hit bit of the checked byte; start = end + 1 - need
    assign hit_end   = bffsa_pkg::SEC_W'({r_chk_idx, scan.pos});
    assign hit_start = bffsa_pkg::SEC_W'(bffsa_pkg::NEED_W'(hit_end) + 1'b1 - r_need);

    // bits of the current mark byte that fall inside [start, end]
    always_comb begin
        mask_lo = (r_mark_idx == r_start[bffsa_pkg::SEC_W-1:3]) ? r_start[2:0] : 3'd0;
        mask_hi = (r_mark_idx == r_end[bffsa_pkg::SEC_W-1:3])   ? r_end[2:0]   : 3'd7;
        for (int j = 0; j < 8; j++) begin
            mark_mask[j] = (3'(j) >= mask_lo) && (3'(j) <= mask_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bffsa_pkg::S_IDLE;
            r_strobe  <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_chk_idx  <= n_chk_idx;
        r_run      <= n_run;
        r_need     <= n_need;
        r_start    <= n_start;
        r_end      <= n_end;
        r_mark_idx <= n_mark_idx;
        r_result   <= n_result;
    end

    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        n_chk_vld  = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_run      = r_run;
        n_need     = r_need;
        n_start    = r_start;
        n_end      = r_end;
        n_mark_idx = r_mark_idx;
        n_strobe   = 1'b0;
        n_result   = r_result;
        ram_req    = '0;

        case (r_state)
            bffsa_pkg::S_IDLE: begin
                if (start) begin
                    n_strobe = 1'b1;
                    n_result = '0;
                    if (i_item.func == bffsa_pkg::FN_LOAD) begin
                        // indexes past the map are dropped, status still "loaded"
                        ram_req.we    = (32'(i_item.map_index) < bffsa_pkg::MAP_BYTES);
                        ram_req.waddr = bffsa_pkg::MAP_AW'(i_item.map_index);
                        ram_req.wdata = i_item.map_value;
                        n_result.status = bffsa_pkg::ST_LOADED;
                    end else if (i_item.size_bytes == 16'd0
                                 || 32'(need) > bffsa_pkg::TOTAL) begin
                        n_result.status = bffsa_pkg::ST_NOSPACE;
                    end else begin
                        n_strobe = 1'b0;
                        n_need   = need;
                        n_run    = '0;
                        n_rd_idx = '0;
                        n_state  = bffsa_pkg::S_SCAN;
                    end
                end
            end

            bffsa_pkg::S_SCAN: begin
                // stream reads one byte ahead of the check
                ram_req.raddr = r_rd_idx[bffsa_pkg::MAP_AW-1:0];
                if (32'(r_rd_idx) < bffsa_pkg::MAP_BYTES) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[bffsa_pkg::MAP_AW-1:0];
                end
                if (r_chk_vld) begin
                    n_run = scan.run;
                    if (scan.hit) begin
                        n_chk_vld  = 1'b0;
                        n_start    = hit_start;
                        n_end      = hit_end;
                        n_mark_idx = hit_start[bffsa_pkg::SEC_W-1:3];
                        n_state    = bffsa_pkg::S_MARK_RD;
                    end else if (32'(r_chk_idx) == bffsa_pkg::MAP_BYTES - 1) begin
                        n_chk_vld       = 1'b0;
                        n_strobe        = 1'b1;
                        n_result        = '0;
                        n_result.status = bffsa_pkg::ST_NOSPACE;
                        n_state         = bffsa_pkg::S_IDLE;
                    end
                end
            end

            bffsa_pkg::S_MARK_RD: begin
                ram_req.raddr = r_mark_idx;
                n_state       = bffsa_pkg::S_MARK_WR;
            end

            bffsa_pkg::S_MARK_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_mark_idx;
                ram_req.wdata = ram_rdata | mark_mask;
                if (r_mark_idx == r_end[bffsa_pkg::SEC_W-1:3]) begin
                    n_strobe               = 1'b1;
                    n_result.status        = bffsa_pkg::ST_OK;
                    n_result.start_sector  = r_start;
                    n_result.start_address = 16'({6'd0, r_start} << bffsa_pkg::SECTOR_SHIFT);
                    n_state                = bffsa_pkg::S_IDLE;
                end else begin
                    n_mark_idx = r_mark_idx + 1'b1;
                    n_state    = bffsa_pkg::S_MARK_RD;
                end
            end

            default: begin
                n_state = bffsa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != bffsa_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* tb/sv/bitmap_first_fit_sector_allocator_test.sv */
// Self-checking testbench for the bitmap first-fit sector allocator.
module bitmap_first_fit_sector_allocator_test;
    import bffsa_pkg::*;

    // Watchdog limit on the length of the whole run.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Quiet tail at the end, longer than the longest allocate.
    localparam int DRAIN_CYCLES = 400;
    localparam int REPORT_MAX   = 10;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_item  = '0;
    logic      o_strobe;
    t_out_item o_result;

    // Predicted copy of the sector map; every sector free after reset.
    logic [7:0] shadow_map [MAP_BYTES] = '{default: 8'h00};
    // Results predicted at acceptance, oldest first.
    t_out_item  pending_results [$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  granted_count  = 0;
    int  refused_count  = 0;
    int  loaded_count   = 0;
    int  cycle_count    = 0;
    // Cleared during the stretch where the sender never pauses.
    bit  idle_enabled   = 1'b1;

    bitmap_first_fit_sector_allocator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    // Timeout watchdog: a lost result or a stuck busy ends up here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Predicts the result of one item and applies it to the shadow map.
    // Allocate: lowest run of ceil(size/64) free sectors, marked used on success.
    function automatic t_out_item first_fit_outcome(input t_in_item it);
        t_out_item r;
        int        need;
        int        run_len;
        int        first;
        int        s;
        int        k;
        r = '0;
        r.status = ST_NOSPACE;
        if (it.func == FN_LOAD) begin
            if (int'(it.map_index) < MAP_BYTES)
                shadow_map[it.map_index] = it.map_value;
            r.status = ST_LOADED;
            return r;
        end
        // zero size is refused and leaves the map alone
        if (it.size_bytes == 16'd0)
            return r;
        need = (int'(it.size_bytes) + SECTOR_BYTES - 1) / SECTOR_BYTES;
        if (need > TOTAL)
            return r;
        run_len = 0;
        for (s = 0; s < TOTAL; s++) begin
            if (shadow_map[s >> 3][s & 7]) begin
                run_len = 0;
            end else begin
                run_len++;
                if (run_len == need) begin
                    first = s + 1 - need;
                    for (k = first; k <= s; k++)
                        shadow_map[k >> 3][k & 7] = 1'b1;
                    r.status        = ST_OK;
                    r.start_sector  = first[9:0];
                    r.start_address = 16'(first * SECTOR_BYTES);
                    return r;
                end
            end
        end
        return r;
    endfunction

    function automatic t_in_item random_fields();
        t_in_item it;
        it.func       = 1'($urandom);
        it.size_bytes = 16'($urandom);
        it.map_index  = 7'($urandom);
        it.map_value  = 8'($urandom);
        return it;
    endfunction

    // Holds start until the block takes the item, then predicts its result.
    // A random pause may follow; otherwise start stays high for the next item.
    task automatic issue_request(input t_in_item it);
        int gap;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(first_fit_outcome(it));
        if (idle_enabled && $urandom_range(99) < 15) begin
            // mostly short gaps, sometimes long enough to land after the result
            gap = ($urandom_range(4) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue_alloc(input logic [15:0] size);
        t_in_item it;
        it            = random_fields();
        it.func       = FN_ALLOC;
        it.size_bytes = size;
        issue_request(it);
    endtask

    task automatic issue_load(input logic [6:0] index, input logic [7:0] value);
        t_in_item it;
        it           = random_fields();
        it.func      = FN_LOAD;
        it.map_index = index;
        it.map_value = value;
        issue_request(it);
    endtask

    // Sender backs off until every predicted result has been seen.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result checker: the block cannot be stalled, so every strobe is a result.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n && o_strobe) begin
            got = o_result;
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result %0d: status %0d sector %0d addr 0x%h",
                             result_count, got.status, got.start_sector, got.start_address);
            end else begin
                want = pending_results.pop_front();
                case (want.status)
                    ST_OK:      granted_count++;
                    ST_NOSPACE: refused_count++;
                    default:    loaded_count++;
                endcase
                if (got.status !== want.status || got.start_sector !== want.start_sector ||
                        got.start_address !== want.start_address) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"result %0d mismatch: expected status %0d sector %0d ",
                                  "addr 0x%h, got status %0d sector %0d addr 0x%h"},
                                 result_count, want.status, want.start_sector,
                                 want.start_address, got.status, got.start_sector,
                                 got.start_address);
                end
            end
        end
    end

    // Zero size, sub-sector sizes and exact multiples of the sector size,
    // all taken from an empty map so the start sectors are easy to follow.
    task automatic test_size_rounding();
        issue_alloc(16'd0);     // refused, map untouched
        issue_alloc(16'd1);     // one sector at 0
        issue_alloc(16'd64);    // exact multiple: one sector at 1
        issue_alloc(16'd65);    // two sectors at 2
        issue_alloc(16'd128);   // exact multiple: two sectors at 4
    endtask

    // Whole-map request, full map, last sector, runs across byte borders,
    // fragmented bytes, and index/value extremes of the load item.
    task automatic test_map_edges();
        issue_load(7'd0, 8'h00);        // map empty again
        issue_alloc(16'hFFFF);          // 1024 sectors: the whole map from 0
        issue_alloc(16'd1);             // full: refused
        issue_load(7'd127, 8'h7F);      // free only the top sector
        issue_alloc(16'd1);             // sector 1023, address 0xFFC0
        issue_alloc(16'd64);            // full again: refused
        issue_load(7'd63, 8'h3F);       // sectors 510, 511 free
        issue_load(7'd64, 8'hFC);       // sectors 512, 513 free
        issue_alloc(16'd256);           // four sectors straddling a byte border: 510
        issue_load(7'd64, 8'hAA);       // only isolated free sectors
        issue_alloc(16'd128);           // no run of two: refused
        issue_alloc(16'd1);             // single sector: 512
        issue_load(7'd0, 8'h00);
        issue_alloc(16'hFFFF);          // only eleven free: refused
        issue_alloc(16'd512);           // eight sectors at 0
        wait_drained();
    endtask

    // Scenarios of map loads with a chosen density followed by allocations,
    // with a few loads mixed in. One block of scenarios runs without pauses.
    task automatic test_random_traffic();
        t_in_item it;
        int       scen;
        int       style;
        int       pick;
        for (scen = 0; scen < 20; scen++) begin
            idle_enabled = !(scen >= 8 && scen < 12);
            style = $urandom_range(3);
            repeat ($urandom_range(30, 50)) begin
                it = random_fields();
                it.func = FN_LOAD;
                case (style)
                    0: if ($urandom_range(99) < 70) it.map_value = 8'h00;   // mostly free
                    1: ;                                                    // random bytes
                    2: it.map_value = 8'h01 << $urandom_range(7);           // sparse use
                    default: if ($urandom_range(1) == 1)                    // mostly used
                        it.map_value = ~(8'h01 << $urandom_range(7));
                    else
                        it.map_value = 8'hFF;
                endcase
                issue_request(it);
            end
            repeat (45) begin
                it = random_fields();
                pick = $urandom_range(99);
                if (pick < 8) begin
                    it.func = FN_LOAD;
                end else begin
                    it.func = FN_ALLOC;
                    pick = $urandom_range(99);
                    if (pick < 5)
                        it.size_bytes = 16'd0;
                    else if (pick < 10)
                        it.size_bytes = 16'hFFFF;
                    else if (pick < 35)
                        it.size_bytes = 16'(SECTOR_BYTES * $urandom_range(1, 16));
                    else if (pick < 80)
                        it.size_bytes = 16'($urandom_range(1, 512));
                    else if (pick < 92)
                        it.size_bytes = 16'($urandom_range(513, 8192));
                end
                issue_request(it);
            end
            if (scen % 4 == 3)
                wait_drained();
        end
        idle_enabled = 1'b1;
    endtask

    initial begin
        // synchronous reset held low, then released
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_size_rounding();
        test_map_edges();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatch_count += pending_results.size();

        $display("Checked %0d results: %0d runs granted, %0d refused, %0d map bytes loaded.",
                 result_count, granted_count, refused_count, loaded_count);
        $display("Covered size rounding, full and fragmented maps, byte-border runs.");
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failing results", mismatch_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
